// File: rtl/core/i2cmts_pkg.sv
// Package for the I2C master transaction sequencer: operation, action and
// bus status codes, plus the structs passed between the sequencer modules.
// No dependencies.
package i2cmts_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_EVENT = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_RX_ACK  = 3'd2,
    ACT_RX_NACK = 3'd3,
    ACT_STOP    = 3'd4,
    ACT_RESTART = 3'd5,
    ACT_ABORT   = 3'd6
  } action_e;

  // TWI master status codes that the sequencer acts upon.
  localparam logic [7:0] SC_START       = 8'h08;
  localparam logic [7:0] SC_REP_START   = 8'h10;
  localparam logic [7:0] SC_W_ADR_ACK   = 8'h18;
  localparam logic [7:0] SC_W_DATA_ACK  = 8'h28;
  localparam logic [7:0] SC_ARB_LOST    = 8'h38;
  localparam logic [7:0] SC_R_ADR_ACK   = 8'h40;
  localparam logic [7:0] SC_R_DATA_ACK  = 8'h50;
  localparam logic [7:0] SC_R_DATA_NACK = 8'h58;
  localparam logic [7:0] SC_NO_STATE    = 8'hF8;

  localparam int PTR_W = 7;

  // Output queue sizing.
  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Decision for one transfer: next state, buffer accesses and result flags.
  typedef struct packed {
    action_e            action;
    logic               busy;
    logic               ok;
    logic [7:0]         status;
    logic [PTR_W-1:0]   ptr;
    logic [PTR_W-1:0]   len;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_pos;
    logic [7:0]         wr_data;
    logic [PTR_W-1:0]   rd_pos;
    logic               tx_sel;
    logic               rd_sel;
  } dec_t;

  // One finished result item.
  typedef struct packed {
    action_e    action;
    logic [7:0] tx_byte;
    logic       busy;
    logic       ok;
    logic [7:0] status;
    logic [7:0] read_data;
  } res_t;

endpackage

// File: rtl/core/i2cmts_decide.sv
// Next-action decoder of the I2C master transaction sequencer.
// Pure combinational logic; depends on i2cmts_pkg.
module i2cmts_decide (
  input  i2cmts_pkg::op_e                   op_i,
  input  logic [5:0]                        index_i,
  input  logic [7:0]                        data_i,
  input  logic [6:0]                        length_i,
  input  logic [7:0]                        status_code_i,
  input  logic                              busy_i,
  input  logic                              ok_i,
  input  logic [7:0]                        status_i,
  input  logic [i2cmts_pkg::PTR_W-1:0]      ptr_i,
  input  logic [i2cmts_pkg::PTR_W-1:0]      len_i,
  output i2cmts_pkg::dec_t                  dec_o
);
  import i2cmts_pkg::*;

  logic [PTR_W-1:0] ptr_base;
  logic [PTR_W-1:0] ptr_inc;

  // Start conditions rewind the pointer to the address byte.
  assign ptr_base = (status_code_i == SC_START || status_code_i == SC_REP_START)
                    ? '0 : ptr_i;
  assign ptr_inc  = ptr_i + PTR_W'(1);

  always_comb begin
    dec_o         = '0;
    dec_o.action  = ACT_NONE;
    dec_o.busy    = busy_i;
    dec_o.ok      = ok_i;
    dec_o.status  = status_i;
    dec_o.ptr     = ptr_i;
    dec_o.len     = len_i;
    dec_o.wr_pos  = {1'b0, index_i};
    dec_o.wr_data = data_i;
    dec_o.rd_pos  = {1'b0, index_i};

    unique case (op_i)
      OP_LOAD: begin
        dec_o.wr_en = !busy_i;
      end
      OP_START: begin
        if (!busy_i) begin
          dec_o.len    = length_i;
          dec_o.ok     = 1'b0;
          dec_o.status = SC_NO_STATE;
          dec_o.busy   = 1'b1;
        end
      end
      OP_READ: begin
        dec_o.rd_sel = !busy_i && ok_i;
      end
      OP_EVENT: begin
        if (busy_i) begin
          dec_o.wr_pos = ptr_i;
          unique case (status_code_i) inside
            SC_START, SC_REP_START, SC_W_ADR_ACK, SC_W_DATA_ACK: begin
              dec_o.rd_pos = ptr_base;
              if (ptr_base < len_i) begin
                dec_o.tx_sel = 1'b1;
                dec_o.ptr    = ptr_base + PTR_W'(1);
                dec_o.action = ACT_SEND;
              end else begin
                dec_o.ptr    = ptr_base;
                dec_o.ok     = 1'b1;
                dec_o.busy   = 1'b0;
                dec_o.action = ACT_STOP;
              end
            end
            SC_R_DATA_ACK: begin
              dec_o.wr_en  = 1'b1;
              dec_o.ptr    = ptr_inc;
              dec_o.action = (({1'b0, ptr_inc} + 8'd1) < {1'b0, len_i})
                             ? ACT_RX_ACK : ACT_RX_NACK;
            end
            SC_R_ADR_ACK: begin
              dec_o.action = (({1'b0, ptr_i} + 8'd1) < {1'b0, len_i})
                             ? ACT_RX_ACK : ACT_RX_NACK;
            end
            SC_R_DATA_NACK: begin
              dec_o.wr_en  = 1'b1;
              dec_o.ok     = 1'b1;
              dec_o.busy   = 1'b0;
              dec_o.action = ACT_STOP;
            end
            SC_ARB_LOST: begin
              dec_o.action = ACT_RESTART;
            end
            default: begin
              dec_o.status = status_code_i;
              dec_o.busy   = 1'b0;
              dec_o.action = ACT_ABORT;
            end
          endcase
        end
      end
      default: begin
        dec_o.action = ACT_NONE;
      end
    endcase
  end

endmodule

// File: rtl/core/i2cmts_out_fifo.sv
// Small output queue for finished sequencer results.
// Depends on i2cmts_pkg for the result struct and queue sizing.
module i2cmts_out_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  i2cmts_pkg::res_t                    push_data_i,
  input  logic                                pop_i,
  output i2cmts_pkg::res_t                    head_o,
  output logic [i2cmts_pkg::FIFO_CNT_W-1:0]   count_o
);
  import i2cmts_pkg::*;

  res_t                  entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FIFO_PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FIFO_PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + FIFO_CNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// File: rtl/core/i2c_master_transaction_sequencer_unit.sv
// I2C master transaction sequencer, top level: transfer buffer, sequencing
// state, result stage and output queue. Depends on i2cmts_pkg,
// i2cmts_decide and i2cmts_out_fifo.
//
// The block drives an interrupt-style I2C master. The host loads the buffer
// (address byte with the R/W bit in bit 0, then data), starts a transfer of
// a given length and then feeds every bus status code as an event; each
// transfer on the input channel yields exactly one result transfer that
// names the next bus action (send a byte, receive with ACK or NACK, stop,
// restart after lost arbitration, or abort), together with the busy flag,
// the success flag and the recorded error status after that step. After a
// successful transfer the host reads received bytes back with the read
// operation. One input transfer can be taken every clock cycle while
// in_stall_o is low. The state update, the buffer write and the buffer
// read happen at the accepting edge, which loads the byte and the result
// flags into the registered result stage; the finished result then enters
// a three-entry output queue. in_stall_o comes from registers only and
// rises when the queue plus the result stage could not absorb another
// item, so a stalled output side pauses the input side without any
// combinational path between out_stall_i and in_stall_o.
// The buffer holds no reset value; a byte that was never loaded or received
// reads back as an arbitrary value.
module i2c_master_transaction_sequencer_unit #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [5:0] index_i,
  input  logic [7:0] data_i,
  input  logic [6:0] length_i,
  input  logic [7:0] status_code_i,

  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] action_o,
  output logic [7:0] tx_byte_o,
  output logic       busy_res_o,
  output logic       last_ok_o,
  output logic [7:0] error_status_o,
  output logic [7:0] read_data_o
);
  import i2cmts_pkg::*;

  localparam int AddrW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int SumW  = FIFO_CNT_W + 1;

  // Sequencing state.
  logic             busy_q;
  logic             ok_q;
  logic [7:0]       status_q;
  logic [PTR_W-1:0] ptr_q;
  logic [PTR_W-1:0] len_q;

  // Transfer buffer.
  logic [7:0]       buf_mem [BUFFER_DEPTH];
  logic [7:0]       rd_data_q;

  dec_t             dec;
  logic             in_accept;
  logic             wr_in_range;
  logic             rd_in_range;
  logic [15:0]      wr_pos_ext;
  logic [15:0]      rd_pos_ext;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;

  // Result stage: flags of the item whose buffer byte is being read.
  logic             s1_valid_q;
  action_e          s1_action_q;
  logic             s1_busy_q;
  logic             s1_ok_q;
  logic [7:0]       s1_status_q;
  logic             s1_tx_sel_q;
  logic             s1_rd_sel_q;

  res_t             s1_res;
  res_t             head;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic             out_pop;

  assign in_accept = in_valid_i && !in_stall_o;

  i2cmts_decide u_decide (
    .op_i          (op_e'(op_i)),
    .index_i       (index_i),
    .data_i        (data_i),
    .length_i      (length_i),
    .status_code_i (status_code_i),
    .busy_i        (busy_q),
    .ok_i          (ok_q),
    .status_i      (status_q),
    .ptr_i         (ptr_q),
    .len_i         (len_q),
    .dec_o         (dec)
  );

  // Positions at or beyond the buffer depth drop writes and read as zero.
  assign wr_in_range = int'(dec.wr_pos) < BUFFER_DEPTH;
  assign rd_in_range = int'(dec.rd_pos) < BUFFER_DEPTH;
  assign wr_pos_ext  = 16'(dec.wr_pos);
  assign rd_pos_ext  = 16'(dec.rd_pos);
  assign wr_addr     = wr_pos_ext[AddrW-1:0];
  assign rd_addr     = rd_pos_ext[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      ok_q       <= 1'b0;
      status_q   <= SC_NO_STATE;
      ptr_q      <= '0;
      len_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
      if (in_accept) begin
        busy_q   <= dec.busy;
        ok_q     <= dec.ok;
        status_q <= dec.status;
        ptr_q    <= dec.ptr;
        len_q    <= dec.len;
      end
    end
  end

  // Buffer port and the result-stage payload; an item that writes the
  // buffer never uses the byte read at the same edge.
  always_ff @(posedge clk_i) begin
    if (in_accept && dec.wr_en && wr_in_range) begin
      buf_mem[wr_addr] <= dec.wr_data;
    end
    if (in_accept) begin
      rd_data_q   <= buf_mem[rd_addr];
      s1_action_q <= dec.action;
      s1_busy_q   <= dec.busy;
      s1_ok_q     <= dec.ok;
      s1_status_q <= dec.status;
      s1_tx_sel_q <= dec.tx_sel && rd_in_range;
      s1_rd_sel_q <= dec.rd_sel && rd_in_range;
    end
  end

  always_comb begin
    s1_res.action    = s1_action_q;
    s1_res.tx_byte   = s1_tx_sel_q ? rd_data_q : 8'h00;
    s1_res.busy      = s1_busy_q;
    s1_res.ok        = s1_ok_q;
    s1_res.status    = s1_status_q;
    s1_res.read_data = s1_rd_sel_q ? rd_data_q : 8'h00;
  end

  assign out_pop = out_valid_o && !out_stall_i;

  i2cmts_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (s1_res),
    .pop_i       (out_pop),
    .head_o      (head),
    .count_o     (fifo_cnt)
  );

  // Room is reserved for the item in the result stage plus one more.
  assign in_stall_o = (SumW'(fifo_cnt) + SumW'(s1_valid_q)) >= SumW'(FIFO_DEPTH);

  assign out_valid_o    = fifo_cnt != '0;
  assign action_o       = head.action;
  assign tx_byte_o      = head.tx_byte;
  assign busy_res_o     = head.busy;
  assign last_ok_o      = head.ok;
  assign error_status_o = head.status;
  assign read_data_o    = head.read_data;

`ifndef SYNTHESIS
  // The queue always has room for the item leaving the result stage.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (SumW'(fifo_cnt) < SumW'(FIFO_DEPTH)))
    else $error("output queue overflow");

  // A transfer becomes busy only through an accepted start operation.
  a_busy_by_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(in_accept && op_i == OP_START))
    else $error("busy set without a start");

  // A stop always marks the transfer as successful and idle.
  a_stop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_action_q == ACT_STOP) |-> (s1_ok_q && !s1_busy_q))
    else $error("stop without success");
`endif

endmodule
